// ----- src/vpt_pkg.sv -----
package vpt_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DIV_BITS  = 48;  // dividend and quotient width of the divide pipeline
  localparam int DSR_BITS  = 32;  // magnitude of w
  localparam int LANES     = 7;   // x, y, z, 1/w, s, t, fog
  localparam int SIZE_BITS = 13;
  localparam int DEPTH_BITS = 17;
  localparam int CFG_AW    = 5;
  localparam int PIPE_LAT  = DIV_BITS + 3;  // start beat to out_valid sample

  localparam logic [SIZE_BITS-1:0]  MAX_VIEWPORT = 13'd4096;
  localparam logic [DEPTH_BITS-1:0] DEPTH_ONE    = 17'd65536;

  // divide lanes
  localparam int LN_X = 0;
  localparam int LN_Y = 1;
  localparam int LN_Z = 2;
  localparam int LN_R = 3;
  localparam int LN_S = 4;
  localparam int LN_T = 5;
  localparam int LN_F = 6;

  typedef enum logic [2:0] {
    REG_VP_X       = 3'd0,
    REG_VP_Y       = 3'd1,
    REG_VP_W       = 3'd2,
    REG_VP_H       = 3'd3,
    REG_SURF_W     = 3'd4,
    REG_SURF_H     = 3'd5,
    REG_DEPTH_NEAR = 3'd6,
    REG_DEPTH_FAR  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] clip_x;
    logic signed [31:0] clip_y;
    logic signed [31:0] clip_z;
    logic signed [31:0] clip_w;
    logic signed [31:0] tex_s;
    logic signed [31:0] tex_t;
    logic signed [31:0] fog_in;
    logic [15:0]        red_in;
    logic [15:0]        green_in;
    logic [15:0]        blue_in;
    logic [15:0]        alpha_in;
  } in_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] win_x;
    logic signed [31:0] win_y;
    logic [16:0]        win_z;
    logic signed [31:0] recip_w;
    logic signed [31:0] s_div_w;
    logic signed [31:0] t_div_w;
    logic signed [31:0] fog_over_w;
    logic [15:0]        red_out;
    logic [15:0]        green_out;
    logic [15:0]        blue_out;
    logic [15:0]        alpha_out;
  } out_t;

  // sideband that rides along the divide pipeline
  typedef struct packed {
    logic             w_nz;
    logic [LANES-1:0] neg;
    logic [15:0]      red;
    logic [15:0]      green;
    logic [15:0]      blue;
    logic [15:0]      alpha;
  } side_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = 32'h7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      sat32 = 32'h8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  function automatic logic [SIZE_BITS-1:0] eff_size(input logic [SIZE_BITS-1:0] vp,
                                                    input logic [SIZE_BITS-1:0] surf);
    logic [SIZE_BITS-1:0] s;
    s = (vp != '0) ? vp : surf;
    eff_size = (s > MAX_VIEWPORT) ? MAX_VIEWPORT : s;
  endfunction

endpackage

// ----- src/vpt_div.sv -----
module vpt_div (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              in_vld,
  input  logic [vpt_pkg::LANES-1:0][vpt_pkg::DIV_BITS-1:0]  in_dvd,
  input  logic [vpt_pkg::DSR_BITS-1:0]                      in_dsr,
  input  vpt_pkg::side_t                                    in_side,
  output logic                                              out_vld,
  output logic [vpt_pkg::LANES-1:0][vpt_pkg::DIV_BITS-1:0]  out_quo,
  output vpt_pkg::side_t                                    out_side
);

  localparam int NST = vpt_pkg::DIV_BITS;
  localparam int NL  = vpt_pkg::LANES;
  localparam int DB  = vpt_pkg::DIV_BITS;
  localparam int RB  = vpt_pkg::DSR_BITS;

  // one quotient bit per stage; the dividend shifts out of dq as quotient shifts in
  logic [NST-1:0]                   vld_r;
  logic [NST-1:0][NL-1:0][RB-1:0]   rem_r;
  logic [NST-1:0][NL-1:0][DB-1:0]   dq_r;
  logic [NST-1:0][RB-1:0]           dsr_r;
  vpt_pkg::side_t                   side_r [NST];

  genvar k;
  generate
    for (k = 0; k < NST; k++) begin : g_stg
      logic                   src_vld;
      logic [NL-1:0][RB-1:0]  src_rem;
      logic [NL-1:0][DB-1:0]  src_dq;
      logic [RB-1:0]          src_dsr;
      vpt_pkg::side_t         src_side;
      logic [NL-1:0][RB-1:0]  rem_nxt;
      logic [NL-1:0][DB-1:0]  dq_nxt;

      if (k == 0) begin : g_first
        assign src_vld  = in_vld;
        assign src_rem  = '0;
        assign src_dq   = in_dvd;
        assign src_dsr  = in_dsr;
        assign src_side = in_side;
      end else begin : g_next
        assign src_vld  = vld_r[k-1];
        assign src_rem  = rem_r[k-1];
        assign src_dq   = dq_r[k-1];
        assign src_dsr  = dsr_r[k-1];
        assign src_side = side_r[k-1];
      end

      always_comb begin
        logic [RB:0] trial;
        for (int l = 0; l < NL; l++) begin
          trial = {src_rem[l], src_dq[l][DB-1]};
          if (trial >= {1'b0, src_dsr}) begin
            rem_nxt[l] = RB'(trial - {1'b0, src_dsr});
            dq_nxt[l]  = {src_dq[l][DB-2:0], 1'b1};
          end else begin
            rem_nxt[l] = trial[RB-1:0];
            dq_nxt[l]  = {src_dq[l][DB-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[k] <= 1'b0;
        end else begin
          vld_r[k] <= src_vld;
        end
      end

      always_ff @(posedge clk) begin
        rem_r[k]  <= rem_nxt;
        dq_r[k]   <= dq_nxt;
        dsr_r[k]  <= src_dsr;
        side_r[k] <= src_side;
      end
    end
  endgenerate

  assign out_vld  = vld_r[NST-1];
  assign out_quo  = dq_r[NST-1];
  assign out_side = side_r[NST-1];

endmodule

// ----- src/viewport_transform_vertex.sv -----
// Channel   Ports                              Handshake
// input     start, busy, in_data               beat when start && !busy
// result    out_valid, out_data                one-cycle strobe, no backpressure
// config    psel penable pwrite paddr pwdata   write at psel && penable && pwrite
//           prdata pready                      pready tied high, 8 regs at 4*i
//
// One vertex per cycle, every cycle: busy never rises.
// The path from the start beat to the out_valid sample runs through the
// radix-2 divide pipeline (one quotient bit per stage, seven lanes share |w|),
// then sign/saturate, the viewport and depth-range multiplies, and the
// rounding/offset/clamp stage that feeds the output register.
// Synchronous active-low reset clears the valid bits; config resets, dfar to one.
module viewport_transform_vertex (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  vpt_pkg::in_t                 in_data,
  output logic                         out_valid,
  output vpt_pkg::out_t                out_data,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [vpt_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int NL = vpt_pkg::LANES;
  localparam int DB = vpt_pkg::DIV_BITS;
  localparam int SB = vpt_pkg::SIZE_BITS;
  localparam int ZB = vpt_pkg::DEPTH_BITS;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [SB-1:0] vp_x_r, vp_y_r, vp_w_r, vp_h_r, surf_w_r, surf_h_r;
  logic [ZB-1:0] dnear_r, dfar_r;
  vpt_pkg::cfg_reg_t cfg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_idx = vpt_pkg::cfg_reg_t'(paddr[vpt_pkg::CFG_AW-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_x_r   <= '0;
      vp_y_r   <= '0;
      vp_w_r   <= '0;
      vp_h_r   <= '0;
      surf_w_r <= '0;
      surf_h_r <= '0;
      dnear_r  <= '0;
      dfar_r   <= vpt_pkg::DEPTH_ONE;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        vpt_pkg::REG_VP_X:       vp_x_r   <= pwdata[SB-1:0];
        vpt_pkg::REG_VP_Y:       vp_y_r   <= pwdata[SB-1:0];
        vpt_pkg::REG_VP_W:       vp_w_r   <= pwdata[SB-1:0];
        vpt_pkg::REG_VP_H:       vp_h_r   <= pwdata[SB-1:0];
        vpt_pkg::REG_SURF_W:     surf_w_r <= pwdata[SB-1:0];
        vpt_pkg::REG_SURF_H:     surf_h_r <= pwdata[SB-1:0];
        vpt_pkg::REG_DEPTH_NEAR: dnear_r  <= pwdata[ZB-1:0];
        vpt_pkg::REG_DEPTH_FAR:  dfar_r   <= pwdata[ZB-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      vpt_pkg::REG_VP_X:       prdata = 32'(vp_x_r);
      vpt_pkg::REG_VP_Y:       prdata = 32'(vp_y_r);
      vpt_pkg::REG_VP_W:       prdata = 32'(vp_w_r);
      vpt_pkg::REG_VP_H:       prdata = 32'(vp_h_r);
      vpt_pkg::REG_SURF_W:     prdata = 32'(surf_w_r);
      vpt_pkg::REG_SURF_H:     prdata = 32'(surf_h_r);
      vpt_pkg::REG_DEPTH_NEAR: prdata = 32'(dnear_r);
      vpt_pkg::REG_DEPTH_FAR:  prdata = 32'(dfar_r);
      default:                 prdata = '0;
    endcase
  end

  // Users must keep config quiet while vertices are in flight; it is unenforced.
  logic [SB-1:0] eff_w, eff_h;
  assign eff_w = vpt_pkg::eff_size(vp_w_r, surf_w_r);
  assign eff_h = vpt_pkg::eff_size(vp_h_r, surf_h_r);

  // ---------------------------------------------------------------------------
  // Front end: magnitudes, signs, and rounding bias folded into the dividend
  // (round half away from zero = floor((|n| + |w|/2) / |w|))
  // ---------------------------------------------------------------------------
  logic [31:0]                 abs_w;
  logic [DB-1:0]               half_w;
  logic [NL-1:0][DB-1:0]       dvd;
  vpt_pkg::side_t              side_in;

  always_comb begin
    abs_w  = vpt_pkg::abs32(in_data.clip_w);
    half_w = DB'(abs_w[31:1]);
    dvd[vpt_pkg::LN_X] = {vpt_pkg::abs32(in_data.clip_x), 16'd0} + half_w;
    dvd[vpt_pkg::LN_Y] = {vpt_pkg::abs32(in_data.clip_y), 16'd0} + half_w;
    dvd[vpt_pkg::LN_Z] = {vpt_pkg::abs32(in_data.clip_z), 16'd0} + half_w;
    dvd[vpt_pkg::LN_R] = (DB'(1) << (2 * vpt_pkg::FRAC_BITS)) + half_w;
    dvd[vpt_pkg::LN_S] = {vpt_pkg::abs32(in_data.tex_s), 16'd0} + half_w;
    dvd[vpt_pkg::LN_T] = {vpt_pkg::abs32(in_data.tex_t), 16'd0} + half_w;
    dvd[vpt_pkg::LN_F] = {vpt_pkg::abs32(in_data.fog_in), 16'd0} + half_w;

    side_in.w_nz               = (in_data.clip_w != '0);
    side_in.neg[vpt_pkg::LN_X] = in_data.clip_x[31] ^ in_data.clip_w[31];
    side_in.neg[vpt_pkg::LN_Y] = in_data.clip_y[31] ^ in_data.clip_w[31];
    side_in.neg[vpt_pkg::LN_Z] = in_data.clip_z[31] ^ in_data.clip_w[31];
    side_in.neg[vpt_pkg::LN_R] = in_data.clip_w[31];
    side_in.neg[vpt_pkg::LN_S] = in_data.tex_s[31] ^ in_data.clip_w[31];
    side_in.neg[vpt_pkg::LN_T] = in_data.tex_t[31] ^ in_data.clip_w[31];
    side_in.neg[vpt_pkg::LN_F] = in_data.fog_in[31] ^ in_data.clip_w[31];
    side_in.red                = in_data.red_in;
    side_in.green              = in_data.green_in;
    side_in.blue               = in_data.blue_in;
    side_in.alpha              = in_data.alpha_in;
  end

  logic                  div_vld;
  logic [NL-1:0][DB-1:0] div_quo;
  vpt_pkg::side_t        div_side;

  vpt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_dvd   (dvd),
    .in_dsr   (abs_w),
    .in_side  (side_in),
    .out_vld  (div_vld),
    .out_quo  (div_quo),
    .out_side (div_side)
  );

  // ---------------------------------------------------------------------------
  // P0: apply sign, clamp NDC to +-2^45, saturate the over-w results
  // ---------------------------------------------------------------------------
  localparam logic signed [DB:0] NDC_LIM = (DB+1)'(64'sd1 <<< 45);

  logic                      p0_vld_r;
  logic signed [2:0][46:0]   ndc_r, ndc_nxt;
  logic [3:0][31:0]          ovw_r, ovw_nxt;
  vpt_pkg::side_t            p0_side_r;

  always_comb begin
    logic signed [DB:0] sq;
    for (int l = 0; l < NL; l++) begin
      sq = div_side.neg[l] ? -$signed({1'b0, div_quo[l]}) : $signed({1'b0, div_quo[l]});
      if (l < 3) begin
        if (sq > NDC_LIM) begin
          ndc_nxt[l] = 47'(NDC_LIM);
        end else if (sq < -NDC_LIM) begin
          ndc_nxt[l] = 47'(-NDC_LIM);
        end else begin
          ndc_nxt[l] = sq[46:0];
        end
      end else begin
        ovw_nxt[l-3] = vpt_pkg::sat32(64'(sq));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_vld_r <= 1'b0;
    end else begin
      p0_vld_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    ndc_r     <= ndc_nxt;
    ovw_r     <= ovw_nxt;
    p0_side_r <= div_side;
  end

  // ---------------------------------------------------------------------------
  // P1: viewport and depth-range products
  // ---------------------------------------------------------------------------
  localparam logic signed [47:0] ONE48 = 48'sd65536;

  logic                p1_vld_r;
  logic signed [61:0]  px_r, px_nxt, py_r, py_nxt;
  logic signed [65:0]  pz_r, pz_nxt;
  logic [3:0][31:0]    p1_ovw_r;
  vpt_pkg::side_t      p1_side_r;

  always_comb begin
    logic signed [47:0] ax, ay, az;
    logic signed [13:0] sw, sh;
    logic signed [17:0] dz;
    // each NDC lane is a signed 47-bit value; sign-extend before the offset
    ax = 48'($signed(ndc_r[0])) + ONE48;
    ay = ONE48 - 48'($signed(ndc_r[1]));
    az = 48'($signed(ndc_r[2])) + ONE48;
    sw = $signed({1'b0, eff_w});
    sh = $signed({1'b0, eff_h});
    dz = $signed({1'b0, dfar_r}) - $signed({1'b0, dnear_r});
    px_nxt = 62'(ax) * 62'(sw);
    py_nxt = 62'(ay) * 62'(sh);
    pz_nxt = 66'(az) * 66'(dz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= p0_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    px_r      <= px_nxt;
    py_r      <= py_nxt;
    pz_r      <= pz_nxt;
    p1_ovw_r  <= ovw_r;
    p1_side_r <= p0_side_r;
  end

  // ---------------------------------------------------------------------------
  // P2: round, add viewport origin / near, saturate and clamp; zero rejects
  // ---------------------------------------------------------------------------
  logic           out_valid_r;
  vpt_pkg::out_t  out_r, out_nxt;

  always_comb begin
    logic [61:0]        apx, apy, hx, hy;
    logic [65:0]        apz, hz;
    logic signed [63:0] wx, wy;
    logic signed [65:0] wz;
    logic               ok;
    apx = px_r[61] ? 62'(-px_r) : px_r;
    apy = py_r[61] ? 62'(-py_r) : py_r;
    apz = pz_r[65] ? 66'(-pz_r) : pz_r;
    hx  = (apx + 62'd1) >> 1;
    hy  = (apy + 62'd1) >> 1;
    hz  = (apz + 66'd65536) >> 17;
    wx  = (64'($signed(vp_x_r)) <<< vpt_pkg::FRAC_BITS)
        + (px_r[61] ? -$signed(64'(hx)) : $signed(64'(hx)));
    wy  = (64'($signed(vp_y_r)) <<< vpt_pkg::FRAC_BITS)
        + (py_r[61] ? -$signed(64'(hy)) : $signed(64'(hy)));
    wz  = $signed(66'(dnear_r)) + (pz_r[65] ? -$signed(hz) : $signed(hz));
    ok  = p1_side_r.w_nz && (eff_w != '0) && (eff_h != '0);

    out_nxt = '0;
    if (ok) begin
      out_nxt.ok    = 1'b1;
      out_nxt.win_x = vpt_pkg::sat32(wx);
      out_nxt.win_y = vpt_pkg::sat32(wy);
      if (wz < 66'sd0) begin
        out_nxt.win_z = '0;
      end else if (wz > $signed(66'(vpt_pkg::DEPTH_ONE))) begin
        out_nxt.win_z = vpt_pkg::DEPTH_ONE;
      end else begin
        out_nxt.win_z = wz[ZB-1:0];
      end
      out_nxt.recip_w    = p1_ovw_r[0];
      out_nxt.s_div_w    = p1_ovw_r[1];
      out_nxt.t_div_w    = p1_ovw_r[2];
      out_nxt.fog_over_w = p1_ovw_r[3];
      out_nxt.red_out    = p1_side_r.red;
      out_nxt.green_out  = p1_side_r.green;
      out_nxt.blue_out   = p1_side_r.blue;
      out_nxt.alpha_out  = p1_side_r.alpha;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  // every accepted beat comes out after the fixed pipeline latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##51 out_valid)
    else $error("vertex beat lost in pipeline");

  // a rejected vertex carries all-zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.ok) |-> (out_data.win_x == '0 && out_data.recip_w == '0
      && out_data.win_z == '0 && out_data.red_out == '0 && out_data.s_div_w == '0))
    else $error("rejected vertex has nonzero fields");

  // depth never leaves [0,1]
  a_depth_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.win_z <= vpt_pkg::DEPTH_ONE))
    else $error("win_z out of range");

  // a zero effective viewport always rejects
  a_zero_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (eff_w == '0 || eff_h == '0)) |-> !out_data.ok)
    else $error("zero viewport accepted");
`endif

endmodule

// ----- sim/tb_viewport_transform_vertex.sv -----
module tb_viewport_transform_vertex;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [127:0] wide_t;

  // Vertex scoreboard: holds its own copy of the viewport/depth registers and
  // the queue of window-space results still owed by the pipeline.
  class vertex_scoreboard;
    logic [12:0] vp_x, vp_y, vp_w, vp_h, surf_w, surf_h;
    logic [16:0] z_near, z_far;
    vpt_pkg::out_t pending[$];

    function new();
      vp_x = '0; vp_y = '0; vp_w = '0; vp_h = '0; surf_w = '0; surf_h = '0;
      z_near = '0; z_far = 17'd65536;
    endfunction

    function void set_reg(vpt_pkg::cfg_reg_t r, logic [31:0] v);
      case (r)
        vpt_pkg::REG_VP_X:       vp_x = v[12:0];
        vpt_pkg::REG_VP_Y:       vp_y = v[12:0];
        vpt_pkg::REG_VP_W:       vp_w = v[12:0];
        vpt_pkg::REG_VP_H:       vp_h = v[12:0];
        vpt_pkg::REG_SURF_W:     surf_w = v[12:0];
        vpt_pkg::REG_SURF_H:     surf_h = v[12:0];
        vpt_pkg::REG_DEPTH_NEAR: z_near = v[16:0];
        vpt_pkg::REG_DEPTH_FAR:  z_far = v[16:0];
        default: ;
      endcase
    endfunction

    // round to nearest, ties away from zero
    function wide_t round_div(wide_t n, wide_t d);
      logic [127:0] un, ud, q;
      un = n < 0 ? -n : n;
      ud = d < 0 ? -d : d;
      q = (un + ud / 2) / ud;
      return ((n < 0) != (d < 0)) ? -wide_t'(q) : wide_t'(q);
    endfunction

    function wide_t clip(wide_t v, wide_t lo, wide_t hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function logic [31:0] to_q32(wide_t v);
      wide_t c;
      c = clip(v, -wide_t'(64'sh8000_0000), wide_t'(64'sh7FFF_FFFF));
      return c[31:0];
    endfunction

    function wide_t size_of(logic [12:0] vp, logic [12:0] surf);
      logic [12:0] s;
      s = (vp != 0) ? vp : surf;
      return (s > 13'd4096) ? wide_t'(4096) : wide_t'(s);
    endfunction

    function void note_vertex(vpt_pkg::in_t v);
      vpt_pkg::out_t e;
      wide_t one, lim, w, ew, eh, nx, ny, nz, wz;
      one = wide_t'(1) <<< 16;
      lim = wide_t'(1) <<< 45;
      w = wide_t'(v.clip_w);
      ew = size_of(vp_w, surf_w);
      eh = size_of(vp_h, surf_h);
      e = '0;
      if (w != 0 && ew != 0 && eh != 0) begin
        nx = clip(round_div(wide_t'(v.clip_x) * one, w), -lim, lim);
        ny = clip(round_div(wide_t'(v.clip_y) * one, w), -lim, lim);
        nz = clip(round_div(wide_t'(v.clip_z) * one, w), -lim, lim);
        e.ok = 1'b1;
        e.win_x = to_q32(wide_t'($signed(vp_x)) * one + round_div((nx + one) * ew, 2));
        e.win_y = to_q32(wide_t'($signed(vp_y)) * one + round_div((one - ny) * eh, 2));
        wz = wide_t'(z_near) + round_div((nz + one) * (wide_t'(z_far) - wide_t'(z_near)),
                                        2 * one);
        wz = clip(wz, 0, 65536);
        e.win_z = wz[16:0];
        e.recip_w = to_q32(round_div(one * one, w));
        e.s_div_w = to_q32(round_div(wide_t'(v.tex_s) * one, w));
        e.t_div_w = to_q32(round_div(wide_t'(v.tex_t) * one, w));
        e.fog_over_w = to_q32(round_div(wide_t'(v.fog_in) * one, w));
        e.red_out = v.red_in;
        e.green_out = v.green_in;
        e.blue_out = v.blue_in;
        e.alpha_out = v.alpha_in;
      end
      pending.push_back(e);
    endfunction

    // compare against the oldest expectation; one string per bad field
    function void check_result(vpt_pkg::out_t g, ref string errs[$]);
      vpt_pkg::out_t e;
      errs.delete();
      if (pending.size() == 0) begin
        errs.push_back($sformatf("unexpected result %h", g));
        return;
      end
      e = pending.pop_front();
      if (g.ok !== e.ok) errs.push_back($sformatf("ok %b exp %b", g.ok, e.ok));
      if (g.win_x !== e.win_x) errs.push_back($sformatf("win_x %h exp %h", g.win_x, e.win_x));
      if (g.win_y !== e.win_y) errs.push_back($sformatf("win_y %h exp %h", g.win_y, e.win_y));
      if (g.win_z !== e.win_z) errs.push_back($sformatf("win_z %h exp %h", g.win_z, e.win_z));
      if (g.recip_w !== e.recip_w)
        errs.push_back($sformatf("recip_w %h exp %h", g.recip_w, e.recip_w));
      if (g.s_div_w !== e.s_div_w)
        errs.push_back($sformatf("s_div_w %h exp %h", g.s_div_w, e.s_div_w));
      if (g.t_div_w !== e.t_div_w)
        errs.push_back($sformatf("t_div_w %h exp %h", g.t_div_w, e.t_div_w));
      if (g.fog_over_w !== e.fog_over_w)
        errs.push_back($sformatf("fog_over_w %h exp %h", g.fog_over_w, e.fog_over_w));
      if (g.red_out !== e.red_out)
        errs.push_back($sformatf("red_out %h exp %h", g.red_out, e.red_out));
      if (g.green_out !== e.green_out)
        errs.push_back($sformatf("green_out %h exp %h", g.green_out, e.green_out));
      if (g.blue_out !== e.blue_out)
        errs.push_back($sformatf("blue_out %h exp %h", g.blue_out, e.blue_out));
      if (g.alpha_out !== e.alpha_out)
        errs.push_back($sformatf("alpha_out %h exp %h", g.alpha_out, e.alpha_out));
    endfunction
  endclass

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  vpt_pkg::in_t  in_data;
  logic          out_valid;
  vpt_pkg::out_t out_data;
  logic          psel, penable, pwrite;
  logic [vpt_pkg::CFG_AW-1:0] paddr;
  logic [31:0]   pwdata, prdata;
  logic          pready;

  vertex_scoreboard sb;
  int          err_count;
  string       field_errs[$];

  viewport_transform_vertex dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #2ms;
    $display("Verification failed");
    $finish;
  end

  task automatic report(string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Results are strobed for one cycle with no backpressure; sample every edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_data, field_errs);
      foreach (field_errs[i]) report(field_errs[i]);
    end
  end

  // Two-phase APB write: setup then access; the register updates on the access edge.
  task automatic cfg_write(vpt_pkg::cfg_reg_t r, logic [31:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= vpt_pkg::CFG_AW'(r) << 2;
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    sb.set_reg(r, v);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drive one vertex; hold start until a beat lands, then drop start only if
  // the next vertex is not sent back to back.
  task automatic send_vertex(vpt_pkg::in_t v);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= v;
    do @(posedge clk); while (busy);
    sb.note_vertex(v);
  endtask

  task automatic end_burst();
    start <= 1'b0;
  endtask

  // Pause the sender until the pipeline has drained, then let it settle.
  task automatic drain();
    int guard;
    end_burst();
    guard = 0;
    while (sb.pending.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (vpt_pkg::PIPE_LAT + 8) @(posedge clk);
  endtask

  // Coordinate generator: mostly moderate values, plus extremes and full random.
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 7))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'($signed($urandom_range(0, 64)) - 32);
      default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
    endcase
  endfunction

  function automatic logic [31:0] pick_w();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return $urandom();
      2: return 32'($signed($urandom_range(0, 8)) - 4);
      3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom_range(0, 1) ? 32'($urandom_range(1, 32'h0004_0000))
                                           : -32'($urandom_range(1, 32'h0004_0000));
    endcase
  endfunction

  function automatic vpt_pkg::in_t rand_vertex();
    vpt_pkg::in_t v;
    v.clip_x = pick_coord();
    v.clip_y = pick_coord();
    v.clip_z = pick_coord();
    v.clip_w = pick_w();
    v.tex_s = pick_coord();
    v.tex_t = pick_coord();
    v.fog_in = pick_coord();
    v.red_in = $urandom();
    v.green_in = $urandom();
    v.blue_in = $urandom();
    v.alpha_in = $urandom();
    return v;
  endfunction

  function automatic vpt_pkg::in_t make_vertex(logic [31:0] x, y, z, w, s, t, f,
                                               logic [15:0] c);
    vpt_pkg::in_t v;
    v.clip_x = x; v.clip_y = y; v.clip_z = z; v.clip_w = w;
    v.tex_s = s; v.tex_t = t; v.fog_in = f;
    v.red_in = c; v.green_in = ~c; v.blue_in = c ^ 16'h5A5A; v.alpha_in = ~c ^ 16'h5A5A;
    return v;
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd4096;
      2: return 32'h1FFF;
      3: return $urandom_range(1, 16);
      default: return $urandom() & 32'h1FFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_origin();
    case ($urandom_range(0, 3))
      0: return 32'h1000;  // -4096 in 13 bits
      1: return 32'h0FFF;
      default: return $urandom() & 32'h1FFF;
    endcase
  endfunction

  function automatic logic [31:0] pick_depth();
    case ($urandom_range(0, 4))
      0: return 32'd0;
      1: return 32'd65536;
      2: return 32'h1FFFF;
      default: return $urandom() & 32'h1FFFF;
    endcase
  endfunction

  // Reprogram every register with a random setting, extremes favored.
  task automatic random_config();
    cfg_write(vpt_pkg::REG_VP_X, pick_origin());
    cfg_write(vpt_pkg::REG_VP_Y, pick_origin());
    cfg_write(vpt_pkg::REG_VP_W, pick_size());
    cfg_write(vpt_pkg::REG_VP_H, pick_size());
    cfg_write(vpt_pkg::REG_SURF_W, pick_size());
    cfg_write(vpt_pkg::REG_SURF_H, pick_size());
    cfg_write(vpt_pkg::REG_DEPTH_NEAR, pick_depth());
    cfg_write(vpt_pkg::REG_DEPTH_FAR, pick_depth());
  endtask

  initial begin
    vpt_pkg::in_t v;
    sb = new();
    err_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: zero viewport and zero drawable, so every vertex is rejected.
    repeat (4) send_vertex(rand_vertex());
    drain();

    // Directed: 640x480 viewport at the origin, full depth range.
    cfg_write(vpt_pkg::REG_VP_X, 32'd0);
    cfg_write(vpt_pkg::REG_VP_Y, 32'd0);
    cfg_write(vpt_pkg::REG_VP_W, 32'd640);
    cfg_write(vpt_pkg::REG_VP_H, 32'd480);
    cfg_write(vpt_pkg::REG_SURF_W, 32'd0);
    cfg_write(vpt_pkg::REG_SURF_H, 32'd0);
    cfg_write(vpt_pkg::REG_DEPTH_NEAR, 32'd0);
    cfg_write(vpt_pkg::REG_DEPTH_FAR, 32'd65536);
    send_vertex(make_vertex(0, 0, 0, 32'h0001_0000, 0, 0, 0, 16'h0000));
    send_vertex(make_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000,
                            32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 16'hFFFF));
    // zero w: rejected, everything cleared
    send_vertex(make_vertex(32'h0001_0000, 32'h0001_0000, 0, 0, 1, 1, 1, 16'h1234));
    // smallest w magnitudes: 1/w and over-w saturate
    send_vertex(make_vertex(1, -1, 1, 32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 5, 16'hA5A5));
    send_vertex(make_vertex(1, -1, -1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 5,
                            16'h00FF));
    // extreme w, extreme coordinates
    send_vertex(make_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'hFF00));
    send_vertex(make_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8001));
    send_vertex(make_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'd3,
                            0, 0, 0, 16'h7FFE));
    // rounding ties: even w with halfway quotients
    send_vertex(make_vertex(32'd1, 32'd3, 32'd5, 32'd2, 32'd1, 32'hFFFF_FFFF, 32'd3,
                            16'h0001));
    send_vertex(make_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFD, 32'd7, 32'hFFFF_FFFE, 32'd3,
                            32'd5, 32'hFFFF_FFFB, 16'h8000));
    // depth far outside the clip volume: clamp to 0 and to 1
    send_vertex(make_vertex(0, 0, 32'h0004_0000, 32'h0001_0000, 0, 0, 0, 16'h0F0F));
    send_vertex(make_vertex(0, 0, 32'hFFFC_0000, 32'h0001_0000, 0, 0, 0, 16'hF0F0));
    drain();

    // Zero viewport size falls back to the drawable size; oversize saturates;
    // near above far and depth registers above one.
    cfg_write(vpt_pkg::REG_VP_X, 32'h1000);
    cfg_write(vpt_pkg::REG_VP_Y, 32'h0FFF);
    cfg_write(vpt_pkg::REG_VP_W, 32'd0);
    cfg_write(vpt_pkg::REG_VP_H, 32'h1FFF);
    cfg_write(vpt_pkg::REG_SURF_W, 32'h1FFF);
    cfg_write(vpt_pkg::REG_SURF_H, 32'd0);
    cfg_write(vpt_pkg::REG_DEPTH_NEAR, 32'h1FFFF);
    cfg_write(vpt_pkg::REG_DEPTH_FAR, 32'd0);
    send_vertex(make_vertex(32'h0001_0000, 32'hFFFF_0000, 0, 32'h0001_0000, 0, 0, 0, 0));
    send_vertex(make_vertex(32'h7FFF_0000, 32'h8000_0000, 32'h0000_8000, 32'd1,
                            0, 0, 0, 16'hFFFF));
    send_vertex(make_vertex(32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000,
                            0, 0, 0, 16'h3C3C));
    drain();
    // Zero in both the viewport and the drawable height: rejected.
    cfg_write(vpt_pkg::REG_VP_H, 32'd0);
    send_vertex(make_vertex(0, 0, 0, 32'h0001_0000, 1, 2, 3, 16'h5555));
    send_vertex(rand_vertex());
    drain();

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < 10; ph++) begin
      random_config();
      // keep most phases usable so vertices get past the reject check
      if ($urandom_range(0, 4) != 0) begin
        cfg_write(vpt_pkg::REG_SURF_W, $urandom_range(1, 8191));
        cfg_write(vpt_pkg::REG_SURF_H, $urandom_range(1, 8191));
      end
      for (int n = 0; n < 53; n++) begin
        v = rand_vertex();
        send_vertex(v);
      end
      drain();
    end

    end_burst();
    if (err_count == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      if (sb.pending.size() != 0) report($sformatf("%0d results never arrived",
                                                   sb.pending.size()));
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/vpt_pkg.sv
src/vpt_div.sv
src/viewport_transform_vertex.sv
sim/tb_viewport_transform_vertex.sv
